### rtl/core/gpss_pkg.sv
// ----------------------------------------------------------------------------
// gpss_pkg
// Shared widths, constants, command and status types for the gcd power sum unit.
// ----------------------------------------------------------------------------
package gpss_pkg;

	localparam int LIM_W      = 16;
	localparam int EXP_W      = 31;
	localparam int VAL_W      = 30;
	localparam int IDX_W      = LIM_W + 1;
	localparam int REM_W      = LIM_W + 2;
	localparam int MUL_W      = 2 * LIM_W;
	localparam int TBL_DEPTH  = 1 << LIM_W;
	localparam int MAX_PRIMES = 6542;
	localparam int PRIME_AW   = $clog2(MAX_PRIMES);
	localparam int PRIME_W    = LIM_W + VAL_W;
	localparam int MM_LAT     = 5;
	localparam int CNT_W      = $clog2(MM_LAT);

	localparam logic [VAL_W-1:0] MODP       = 30'd1000000007;
	localparam logic [63:0]      BAR_M_FULL = (64'd1 << 62) / 64'd1000000007;
	localparam logic [32:0]      BAR_M      = BAR_M_FULL[32:0];

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLR,
		OP_INIT,
		OP_SV_RD,
		OP_SV_CHK,
		OP_POW_INIT,
		OP_POW_A,
		OP_POW_B,
		OP_POW_CA,
		OP_POW_CB,
		OP_POW_DONE,
		OP_SV_PR,
		OP_SV_PC,
		OP_SV_MUL,
		OP_SV_WR,
		OP_INC_I,
		OP_HM_INIT,
		OP_HM_RD,
		OP_HM_GI,
		OP_HM_MR,
		OP_HM_MW,
		OP_FIN_INIT,
		OP_FIN_RD,
		OP_FIN_MUL,
		OP_FIN_ACC,
		OP_FIN_STEP,
		OP_FIN_FIX,
		OP_DONE
	} dp_op_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_CLR,
		ST_INIT,
		ST_SV_RD,
		ST_SV_CHK,
		ST_POW_INIT,
		ST_POW_STEP,
		ST_POW_A,
		ST_POW_B,
		ST_POW_W,
		ST_POW_CA,
		ST_POW_CB,
		ST_POW_DONE,
		ST_SV_PR,
		ST_SV_PC,
		ST_SV_MUL,
		ST_SV_W,
		ST_SV_WR,
		ST_SV_NEXT,
		ST_HM_INIT,
		ST_HM_RD,
		ST_HM_GI,
		ST_HM_MR,
		ST_HM_MW,
		ST_HM_NEXT,
		ST_FIN_INIT,
		ST_FIN_RD,
		ST_FIN_MUL,
		ST_FIN_W,
		ST_FIN_ACC,
		ST_FIN_STEP,
		ST_FIN_FIX,
		ST_DONE
	} gpss_state_t;

	typedef struct packed {
		dp_op_t op;
	} gpss_cmd_t;

	typedef struct packed {
		logic i_last;
		logic prime;
		logic n_small;
		logic n_zero;
		logic e_zero;
		logic over;
		logic p_is_s;
		logic hm_end;
		logic hm_more;
		logic rem_neg;
	} gpss_sts_t;

	function automatic logic [VAL_W-1:0] add_mod(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, MODP}) begin
			s = s - {1'b0, MODP};
		end
		return s[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		s = {1'b0, a} - {1'b0, b};
		if (s[VAL_W]) begin
			s = s + {1'b0, MODP};
		end
		return s[VAL_W-1:0];
	endfunction

endpackage

### rtl/core/gcd_power_sum_sieve_unit.sv
// ----------------------------------------------------------------------------
// gcd_power_sum_sieve_unit
// Sum of gcd(a,b)^k over 1 <= a,b <= n, mod 1e9+7, via a sieve for i^k,
// in-place divisor inversion to Jordan's totient and a floor(n/d) sweep.
//
//   channel   direction   handshake          payload
//   request   in          start & !busy      limit, exponent
//   result    out         done (one cycle)   total
//
// One request at a time; busy stays high from acceptance until the cycle
// in which done pulses. Run time per request covers the spf clear, the
// power of each prime, the composite writes, the inversion sweep and the
// quotient steps, and is set by the pipelined modular multiplier and one
// read port per table.
// Reset is asynchronous; tables need no reset. Results cannot be stalled.
// ----------------------------------------------------------------------------
module gcd_power_sum_sieve_unit import gpss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [LIM_W-1:0] limit,
	input  logic [EXP_W-1:0] exponent,
	output logic             done,
	output logic [VAL_W-1:0] total
);

	gpss_cmd_t cmd;
	gpss_sts_t sts;

	gpss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	gpss_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.limit    (limit),
		.exponent (exponent),
		.cmd      (cmd),
		.sts      (sts),
		.done     (done),
		.total    (total)
	);

endmodule

### rtl/core/gpss_ram.sv
// ----------------------------------------------------------------------------
// gpss_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gpss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/gpss_modmul.sv
// ----------------------------------------------------------------------------
// gpss_modmul
// Pipelined modular multiplier, a * b mod 1e9+7, Barrett reduction.
// ----------------------------------------------------------------------------
module gpss_modmul import gpss_pkg::*; (
	input  logic             clk,
	input  logic [VAL_W-1:0] a,
	input  logic [MUL_W-1:0] b,
	output logic [VAL_W-1:0] y
);

	logic [61:0] x_s1, x_s2;
	logic [65:0] t_s2;
	logic [32:0] x_s3, y_s3, r_s4;
	logic [62:0] qp;
	logic [VAL_W-1:0] res_s5;
	logic [32:0] corr;

	assign qp = 63'(t_s2[65:33]) * 63'(MODP);

	always_comb begin
		corr = r_s4;
		if (r_s4 >= 33'(2 * 64'd1000000007)) begin
			corr = r_s4 - 33'(2 * 64'd1000000007);
		end else if (r_s4 >= 33'(MODP)) begin
			corr = r_s4 - 33'(MODP);
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= 62'(a) * 62'(b);
		t_s2   <= 66'(x_s1[61:29]) * 66'(BAR_M);
		x_s2   <= x_s1;
		y_s3   <= qp[32:0];
		x_s3   <= x_s2[32:0];
		r_s4   <= x_s3 - y_s3;
		res_s5 <= corr[VAL_W-1:0];
	end

	assign y = res_s5;

endmodule

### rtl/core/gpss_dp.sv
// ----------------------------------------------------------------------------
// gpss_dp
// Datapath: sieve tables, prime list, modular multiplier and accumulators.
// ----------------------------------------------------------------------------
module gpss_dp import gpss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LIM_W-1:0] limit,
	input  logic [EXP_W-1:0] exponent,
	input  gpss_cmd_t        cmd,
	output gpss_sts_t        sts,
	output logic             done,
	output logic [VAL_W-1:0] total
);

	logic [LIM_W-1:0]        n_q, s_q, p_q, q_q;
	logic [EXP_W-1:0]        k_q, e_q;
	logic [IDX_W-1:0]        i_q, d_q, n_ext, d_next;
	logic [PRIME_AW-1:0]     j_q, np_q;
	logic [VAL_W-1:0]        gi_q, pk_q, base_q, acc_q, tot_q, total_q;
	logic signed [REM_W-1:0] r_q;
	logic [MUL_W-1:0]        qsq_q;
	logic                    done_q;

	logic                    g_we, s_we, p_we;
	logic [LIM_W-1:0]        g_wa, g_ra, s_wa, s_wd, s_rd;
	logic [VAL_W-1:0]        g_wd, g_rd;
	logic [PRIME_W-1:0]      p_wd, p_rd;
	logic [VAL_W-1:0]        mm_a, mm_y;
	logic [MUL_W-1:0]        mm_b;
	logic [IDX_W+LIM_W-1:0]  d_prod;
	logic [LIM_W-1:0]        pr_p;
	logic [VAL_W-1:0]        pr_pk;

	assign n_ext  = {1'b0, n_q};
	assign d_next = d_q + i_q;
	assign pr_p   = p_rd[PRIME_W-1:VAL_W];
	assign pr_pk  = p_rd[VAL_W-1:0];
	assign d_prod = (IDX_W+LIM_W)'(i_q) * (IDX_W+LIM_W)'(pr_p);

	always_comb begin
		g_we = 1'b0;
		g_wa = i_q[LIM_W-1:0];
		g_wd = acc_q;
		g_ra = i_q[LIM_W-1:0];
		s_we = 1'b0;
		s_wa = i_q[LIM_W-1:0];
		s_wd = '0;
		p_we = 1'b0;
		p_wd = {i_q[LIM_W-1:0], acc_q};
		mm_a = '0;
		mm_b = '0;
		unique case (cmd.op)
			OP_CLR: begin
				s_we = 1'b1;
			end
			OP_INIT: begin
				g_we = 1'b1;
				g_wa = LIM_W'(1);
				g_wd = VAL_W'(1);
			end
			OP_POW_A: begin
				mm_a = acc_q;
				mm_b = MUL_W'(base_q);
			end
			OP_POW_B: begin
				mm_a = base_q;
				mm_b = MUL_W'(base_q);
			end
			OP_POW_DONE: begin
				g_we = 1'b1;
				p_we = 1'b1;
			end
			OP_SV_MUL: begin
				s_we = 1'b1;
				s_wa = d_q[LIM_W-1:0];
				s_wd = p_q;
				mm_a = gi_q;
				mm_b = MUL_W'(pk_q);
			end
			OP_SV_WR: begin
				g_we = 1'b1;
				g_wa = d_q[LIM_W-1:0];
				g_wd = mm_y;
			end
			OP_HM_MR: begin
				g_ra = d_q[LIM_W-1:0];
			end
			OP_HM_MW: begin
				g_we = 1'b1;
				g_wa = d_q[LIM_W-1:0];
				g_wd = sub_mod(g_rd, gi_q);
				g_ra = d_next[LIM_W-1:0];
			end
			OP_FIN_MUL: begin
				mm_a = g_rd;
				mm_b = qsq_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				n_q <= limit;
				k_q <= exponent;
				i_q <= '0;
			end
			OP_CLR: begin
				i_q <= i_q + IDX_W'(1);
			end
			OP_INIT: begin
				i_q  <= IDX_W'(2);
				np_q <= '0;
			end
			OP_SV_CHK: begin
				s_q  <= s_rd;
				gi_q <= g_rd;
				j_q  <= '0;
			end
			OP_POW_INIT: begin
				base_q <= VAL_W'(i_q);
				acc_q  <= VAL_W'(1);
				e_q    <= k_q;
				s_q    <= i_q[LIM_W-1:0];
			end
			OP_POW_CA: begin
				if (e_q[0]) begin
					acc_q <= mm_y;
				end
			end
			OP_POW_CB: begin
				base_q <= mm_y;
				e_q    <= e_q >> 1;
			end
			OP_POW_DONE: begin
				np_q <= np_q + PRIME_AW'(1);
				gi_q <= acc_q;
			end
			OP_SV_PC: begin
				p_q  <= pr_p;
				pk_q <= pr_pk;
				d_q  <= d_prod[IDX_W-1:0];
			end
			OP_SV_WR: begin
				j_q <= j_q + PRIME_AW'(1);
			end
			OP_INC_I: begin
				i_q <= i_q + IDX_W'(1);
			end
			OP_HM_INIT: begin
				i_q <= IDX_W'(1);
			end
			OP_HM_RD: begin
				d_q <= {i_q[IDX_W-2:0], 1'b0};
			end
			OP_HM_GI: begin
				gi_q <= g_rd;
			end
			OP_HM_MW: begin
				d_q <= d_next;
			end
			OP_FIN_INIT: begin
				i_q   <= IDX_W'(1);
				q_q   <= n_q;
				r_q   <= '0;
				tot_q <= '0;
			end
			OP_FIN_RD: begin
				qsq_q <= MUL_W'(q_q) * MUL_W'(q_q);
			end
			OP_FIN_ACC: begin
				tot_q <= add_mod(tot_q, mm_y);
			end
			OP_FIN_STEP: begin
				i_q <= i_q + IDX_W'(1);
				r_q <= r_q - $signed({2'b00, q_q});
			end
			OP_FIN_FIX: begin
				q_q <= q_q - LIM_W'(1);
				r_q <= r_q + $signed({1'b0, i_q});
			end
			OP_DONE: begin
				total_q <= tot_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.op == OP_DONE);
		end
	end

	gpss_ram #(.WIDTH(VAL_W), .DEPTH(TBL_DEPTH)) u_gmem (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_wa),
		.wdata (g_wd),
		.raddr (g_ra),
		.rdata (g_rd)
	);

	gpss_ram #(.WIDTH(LIM_W), .DEPTH(TBL_DEPTH)) u_spf_mem (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_wa),
		.wdata (s_wd),
		.raddr (i_q[LIM_W-1:0]),
		.rdata (s_rd)
	);

	gpss_ram #(.WIDTH(PRIME_W), .DEPTH(MAX_PRIMES)) u_prime_mem (
		.clk   (clk),
		.we    (p_we),
		.waddr (np_q),
		.wdata (p_wd),
		.raddr (j_q),
		.rdata (p_rd)
	);

	gpss_modmul u_mm (
		.clk (clk),
		.a   (mm_a),
		.b   (mm_b),
		.y   (mm_y)
	);

	always_comb begin
		sts.i_last  = (i_q == n_ext);
		sts.prime   = (s_rd == '0);
		sts.n_small = (n_q < LIM_W'(2));
		sts.n_zero  = (n_q == '0);
		sts.e_zero  = (e_q == '0);
		sts.over    = (d_prod > (IDX_W+LIM_W)'(n_q));
		sts.p_is_s  = (p_q == s_q);
		sts.hm_end  = (d_q > n_ext);
		sts.hm_more = (d_next <= n_ext);
		sts.rem_neg = r_q[REM_W-1];
	end

	assign done  = done_q;
	assign total = total_q;

endmodule

### rtl/core/gpss_ctrl.sv
// ----------------------------------------------------------------------------
// gpss_ctrl
// Controller: sequences clear, sieve, inversion and quotient summation phases.
// ----------------------------------------------------------------------------
module gpss_ctrl import gpss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  gpss_sts_t sts,
	output gpss_cmd_t cmd,
	output logic      busy
);

	gpss_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = ST_CLR;
				end
			end
			ST_CLR: begin
				cmd.op = OP_CLR;
				if (sts.i_last) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.op  = OP_INIT;
				state_d = sts.n_small ? ST_FIN_INIT : ST_SV_RD;
			end
			ST_SV_RD: begin
				cmd.op  = OP_SV_RD;
				state_d = ST_SV_CHK;
			end
			ST_SV_CHK: begin
				cmd.op  = OP_SV_CHK;
				state_d = sts.prime ? ST_POW_INIT : ST_SV_PR;
			end
			ST_POW_INIT: begin
				cmd.op  = OP_POW_INIT;
				state_d = ST_POW_STEP;
			end
			ST_POW_STEP: begin
				state_d = sts.e_zero ? ST_POW_DONE : ST_POW_A;
			end
			ST_POW_A: begin
				cmd.op  = OP_POW_A;
				state_d = ST_POW_B;
			end
			ST_POW_B: begin
				cmd.op  = OP_POW_B;
				cnt_d   = CNT_W'(MM_LAT - 3);
				state_d = ST_POW_W;
			end
			ST_POW_W: begin
				if (cnt_q == '0) begin
					state_d = ST_POW_CA;
				end else begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			ST_POW_CA: begin
				cmd.op  = OP_POW_CA;
				state_d = ST_POW_CB;
			end
			ST_POW_CB: begin
				cmd.op  = OP_POW_CB;
				state_d = ST_POW_STEP;
			end
			ST_POW_DONE: begin
				cmd.op  = OP_POW_DONE;
				state_d = ST_SV_PR;
			end
			ST_SV_PR: begin
				cmd.op  = OP_SV_PR;
				state_d = ST_SV_PC;
			end
			ST_SV_PC: begin
				cmd.op  = OP_SV_PC;
				state_d = sts.over ? ST_SV_NEXT : ST_SV_MUL;
			end
			ST_SV_MUL: begin
				cmd.op  = OP_SV_MUL;
				cnt_d   = CNT_W'(MM_LAT - 2);
				state_d = ST_SV_W;
			end
			ST_SV_W: begin
				if (cnt_q == '0) begin
					state_d = ST_SV_WR;
				end else begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			ST_SV_WR: begin
				cmd.op  = OP_SV_WR;
				state_d = sts.p_is_s ? ST_SV_NEXT : ST_SV_PR;
			end
			ST_SV_NEXT: begin
				if (sts.i_last) begin
					state_d = ST_HM_INIT;
				end else begin
					cmd.op  = OP_INC_I;
					state_d = ST_SV_RD;
				end
			end
			ST_HM_INIT: begin
				cmd.op  = OP_HM_INIT;
				state_d = ST_HM_RD;
			end
			ST_HM_RD: begin
				cmd.op  = OP_HM_RD;
				state_d = ST_HM_GI;
			end
			ST_HM_GI: begin
				cmd.op  = OP_HM_GI;
				state_d = sts.hm_end ? ST_FIN_INIT : ST_HM_MR;
			end
			ST_HM_MR: begin
				cmd.op  = OP_HM_MR;
				state_d = ST_HM_MW;
			end
			ST_HM_MW: begin
				cmd.op  = OP_HM_MW;
				state_d = sts.hm_more ? ST_HM_MW : ST_HM_NEXT;
			end
			ST_HM_NEXT: begin
				cmd.op  = OP_INC_I;
				state_d = ST_HM_RD;
			end
			ST_FIN_INIT: begin
				cmd.op  = OP_FIN_INIT;
				state_d = sts.n_zero ? ST_DONE : ST_FIN_RD;
			end
			ST_FIN_RD: begin
				cmd.op  = OP_FIN_RD;
				state_d = ST_FIN_MUL;
			end
			ST_FIN_MUL: begin
				cmd.op  = OP_FIN_MUL;
				cnt_d   = CNT_W'(MM_LAT - 2);
				state_d = ST_FIN_W;
			end
			ST_FIN_W: begin
				if (cnt_q == '0) begin
					state_d = ST_FIN_ACC;
				end else begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			ST_FIN_ACC: begin
				cmd.op  = OP_FIN_ACC;
				state_d = sts.i_last ? ST_DONE : ST_FIN_STEP;
			end
			ST_FIN_STEP: begin
				cmd.op  = OP_FIN_STEP;
				state_d = ST_FIN_FIX;
			end
			ST_FIN_FIX: begin
				if (sts.rem_neg) begin
					cmd.op = OP_FIN_FIX;
				end else begin
					state_d = ST_FIN_RD;
				end
			end
			ST_DONE: begin
				cmd.op  = OP_DONE;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### rtl/core/gpss_checker.sv
// ----------------------------------------------------------------------------
// gpss_checker
// Port-level checks of the gcd power sum unit, bound to the top level.
// ----------------------------------------------------------------------------
module gpss_checker import gpss_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [VAL_W-1:0] total
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but busy not raised");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $fell(busy)))
		else $error("done without end of request");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done longer than one cycle");

	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request ended without result");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (total < MODP))
		else $error("total not reduced");

endmodule

bind gcd_power_sum_sieve_unit gpss_checker u_gpss_checker (.*);

### tb/gcd_power_sum_sieve_unit_tb.sv
// ----------------------------------------------------------------------------
// gcd_power_sum_sieve_unit_tb
// Drives limit/exponent requests (directed table, then random) with random
// gaps, predicts each total with a sieve model of its own and compares
// every done pulse against the oldest pending total.
// ----------------------------------------------------------------------------
module gcd_power_sum_sieve_unit_tb import gpss_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned PRIME = 64'd1000000007;
	localparam int N_RANDOM = 90;

	typedef struct {
		logic [LIM_W-1:0] lim;
		logic [EXP_W-1:0] k;
		bit               known;
		logic [VAL_W-1:0] val;
	} req_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [LIM_W-1:0] limit;
	logic [EXP_W-1:0] exponent;
	logic             done;
	logic [VAL_W-1:0] total;

	logic [VAL_W-1:0] pending_totals[$];
	int               mismatches;

	longint unsigned jk_tab[0:TBL_DEPTH-1];
	bit              comp_tab[0:TBL_DEPTH-1];
	longint unsigned cnt_tab[0:TBL_DEPTH-1];
	longint unsigned part_tab[0:TBL_DEPTH-1];
	longint unsigned prime_tab[0:TBL_DEPTH-1];

	gcd_power_sum_sieve_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.limit    (limit),
		.exponent (exponent),
		.done     (done),
		.total    (total)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e);
		longint unsigned acc;
		acc = 1;
		b = b % PRIME;
		while (e != 0) begin
			if (e[0]) begin
				acc = acc * b % PRIME;
			end
			b = b * b % PRIME;
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic longint unsigned jordan_pp(longint unsigned p, longint unsigned a,
		longint unsigned k);
		longint unsigned pk;
		pk = pow_mod(p, k);
		return (pow_mod(pk, a) + PRIME - pow_mod(pk, a - 1)) % PRIME;
	endfunction

	function automatic logic [VAL_W-1:0] gcd_power_total(longint unsigned n,
		longint unsigned k);
		longint unsigned np, i, j, p, d, part, rest, c, q, u, blk, acc;
		np = 0;
		acc = 0;
		for (int x = 0; x < TBL_DEPTH; x++) begin
			comp_tab[x] = 1'b0;
		end
		jk_tab[0] = 0;
		jk_tab[1] = 1;
		for (i = 2; i <= n; i++) begin
			if (!comp_tab[i]) begin
				jk_tab[i] = jordan_pp(i, 1, k);
				prime_tab[np] = i;
				np++;
				cnt_tab[i] = 1;
				part_tab[i] = i;
			end
			for (j = 0; j < np; j++) begin
				p = prime_tab[j];
				d = i * p;
				if (d > n) begin
					break;
				end
				comp_tab[d] = 1'b1;
				if (i % p == 0) begin
					part = part_tab[i];
					rest = (part != 0) ? i / part : 0;
					c = cnt_tab[i] + 1;
					jk_tab[d] = jk_tab[rest & 65535] * jordan_pp(p, c, k) % PRIME;
					cnt_tab[d] = c & 31;
					part_tab[d] = part * p;
					break;
				end else begin
					jk_tab[d] = jk_tab[i] * jordan_pp(p, 1, k) % PRIME;
					cnt_tab[d] = 1;
					part_tab[d] = p;
				end
			end
		end
		for (i = 1; i <= n; i++) begin
			jk_tab[i] = (jk_tab[i] + jk_tab[i-1]) % PRIME;
		end
		i = 1;
		while (i <= n) begin
			q = n / i;
			u = n / q;
			blk = (jk_tab[u] + PRIME - jk_tab[i-1]) % PRIME;
			acc = (acc + (q * q % PRIME) * blk) % PRIME;
			i = u + 1;
		end
		return acc[VAL_W-1:0];
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_totals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: total=%0d", total);
				end
			end else begin
				if (total !== pending_totals[0]) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("total mismatch: expected %0d actual %0d",
							pending_totals[0], total);
					end
				end
				void'(pending_totals.pop_front());
			end
		end
	end

	task automatic send_request(input req_row_t r);
		int gap;
		logic [VAL_W-1:0] want;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		want = gcd_power_total(r.lim, r.k);
		if (r.known && want != r.val) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("table total wrong: limit=%0d expected %0d model %0d",
					r.lim, r.val, want);
			end
		end
		start    <= 1'b1;
		limit    <= r.lim;
		exponent <= r.k;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		pending_totals = {pending_totals, (r.known ? r.val : want)};
	endtask

	initial begin
		req_row_t directed[$];
		req_row_t r;
		mismatches = 0;
		start      = 1'b0;
		limit      = '0;
		exponent   = '0;
		arst_n     = 1'b0;
		directed = '{
			'{16'd0,     31'd0,          1'b1, 30'd0},
			'{16'd0,     31'h7fffffff,   1'b1, 30'd0},
			'{16'd1,     31'd0,          1'b1, 30'd1},
			'{16'd1,     31'h7fffffff,   1'b1, 30'd1},
			'{16'd1000,  31'd0,          1'b1, 30'd1000000},
			'{16'd2,     31'd1,          1'b1, 30'd5},
			'{16'd2,     31'd0,          1'b1, 30'd4},
			'{16'd3,     31'd1,          1'b0, 30'd0},
			'{16'd4,     31'd2,          1'b0, 30'd0},
			'{16'd16,    31'd5,          1'b0, 30'd0},
			'{16'd64,    31'h7fffffff,   1'b0, 30'd0},
			'{16'd100,   31'h40000000,   1'b0, 30'd0},
			'{16'd210,   31'd1000000006, 1'b0, 30'd0},
			'{16'd256,   31'd3,          1'b0, 30'd0},
			'{16'd500,   31'h55555555,   1'b0, 30'd0},
			'{16'd65535, 31'd1,          1'b0, 30'd0}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[x]) begin
			send_request(directed[x]);
		end
		start <= 1'b0;
		wait (pending_totals.size() == 0);
		for (int n = 0; n < N_RANDOM; n++) begin
			r.known = 1'b0;
			r.val   = '0;
			r.lim   = ($urandom_range(0, 9) == 0) ? LIM_W'($urandom_range(0, 2000))
				: LIM_W'($urandom_range(0, 200));
			case ($urandom_range(0, 3))
				0: r.k = EXP_W'($urandom_range(0, 8));
				1: r.k = EXP_W'($urandom_range(0, 65535));
				default: r.k = EXP_W'($urandom());
			endcase
			if (n == N_RANDOM / 2) begin
				start <= 1'b0;
				wait (pending_totals.size() == 0);
			end
			send_request(r);
		end
		start <= 1'b0;
		wait (pending_totals.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#100_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
